@@ design/bsa_pkg.sv @@
// bsa_pkg: shared sizes, request and status codes, and the token that walks the cell chain
// of the bitmap slot allocator.
// No dependencies; every other design file imports this package.
package bsa_pkg;

	localparam int NUM_WORDS = 16;
	localparam int WORD_BITS = 64;
	localparam int IDX_W     = 10;
	localparam int KIND_W    = 2;
	localparam int STATUS_W  = 2;
	localparam int OFF_W     = $clog2(WORD_BITS);
	localparam int WSEL_W    = IDX_W - OFF_W;
	localparam int CNT_W     = $clog2(NUM_WORDS + 1);
	localparam int CMP_W     = ((WSEL_W > CNT_W) ? WSEL_W : CNT_W) + 1;

	localparam logic [KIND_W-1:0] KIND_GET   = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SET   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd2;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic                read_bit;
		logic [IDX_W-1:0]    granted_index;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	// one request in flight along the chain, with the words-in-use count riding along
	typedef struct packed {
		logic              valid;
		logic              done;
		logic [KIND_W-1:0] kind;
		logic [IDX_W-1:0]  idx;
		logic              val;
		logic [CNT_W-1:0]  wiu;
		rsp_t              rsp;
	} tok_t;

endpackage

@@ design/bsa_req_if.sv @@
// bsa_req_if: request channel of the bitmap slot allocator (valid/ready plus payload).
// Depends on bsa_pkg for field widths.
interface bsa_req_if
	import bsa_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [KIND_W-1:0] kind;
	logic [IDX_W-1:0]  bit_index;
	logic              bit_value;

	modport source(output valid, output kind, output bit_index, output bit_value, input ready);
	modport sink(input valid, input kind, input bit_index, input bit_value, output ready);
endinterface

@@ design/bsa_rsp_if.sv @@
// bsa_rsp_if: result channel of the bitmap slot allocator (valid/ready plus payload).
// Depends on bsa_pkg for field widths.
interface bsa_rsp_if
	import bsa_pkg::*;
();
	logic                valid;
	logic                ready;
	logic                read_bit;
	logic [IDX_W-1:0]    granted_index;
	logic [STATUS_W-1:0] status;

	modport source(output valid, output read_bit, output granted_index, output status,
		input ready);
	modport sink(input valid, input read_bit, input granted_index, input status,
		output ready);
endinterface

@@ design/bitmap_slot_allocator_core.sv @@
// Bitmap slot allocator: 16 words of 64 bits with a growable count of words in use.
// Requests arrive on req (valid/ready, kind / bit_index / bit_value); each gives one
// transaction on rsp (read_bit / granted_index / status).
//   get      reads one bit, status out-of-range when the word is not in use
//   set      writes one bit, growing the words in use to cover the index
//   allocate takes the lowest clear bit of the words in use, else opens a new word
//            at bit 0; status full when every word is taken
// Each request enters a chain of 16 cells, one word per cell, and walks it one cell
// per cycle; the cell that owns the word (or the first with a free bit) serves it.
// The first cell takes the request at the accepting edge, 15 more cells finish the walk,
// and the result then passes through the output register to rsp.valid. req.ready comes
// back together with rsp.valid, so one request is in the chain at a time and a new
// request is not taken until the last one has left the chain.
// A result waiting on a stalled rsp does not block the next request; its result is
// parked in a one-entry hold register, and req.ready stays low while that is full.
// Reset (arst_n low) clears every word, the count and all valid flags at once; the
// block can take a request as soon as reset is released.
// Depends on bsa_pkg, bsa_req_if, bsa_rsp_if and bsa_cell.
module bitmap_slot_allocator_core
	import bsa_pkg::*;
(
	input logic      clk,
	input logic      arst_n,
	bsa_req_if.sink  req,
	bsa_rsp_if.source rsp
);

	tok_t              chain [NUM_WORDS+1];
	tok_t              inj;
	tok_t              tail;
	rsp_t              fin;
	rsp_t              out_q;
	rsp_t              hold_q;
	logic              out_valid_q;
	logic              hold_valid_q;
	logic              busy_q;
	logic [CNT_W-1:0]  wiu_q;
	logic              accept;
	logic              out_free;
	logic [WSEL_W-1:0] in_word;

	assign req.ready = !busy_q && !hold_valid_q;
	assign accept    = req.valid && req.ready;
	assign in_word   = req.bit_index[IDX_W-1:OFF_W];

	// entry: cases settled before the walk go in already done
	always_comb begin
		inj       = '0;
		inj.valid = accept;
		inj.kind  = req.kind;
		inj.idx   = req.bit_index;
		inj.val   = req.bit_value;
		inj.wiu   = wiu_q;
		case (req.kind)
			KIND_GET: begin
				if (CMP_W'(in_word) >= CMP_W'(wiu_q)) begin
					inj.done       = 1'b1;
					inj.rsp.status = ST_RANGE;
				end
			end
			KIND_SET: begin
				if (CMP_W'(in_word) >= CMP_W'(NUM_WORDS)) begin
					inj.done       = 1'b1;
					inj.rsp.status = ST_FULL;
				end
			end
			KIND_ALLOC: begin
			end
			default: begin
				inj.done = 1'b1;
			end
		endcase
	end

	assign chain[0] = inj;

	for (genvar g = 0; g < NUM_WORDS; g++) begin : g_cell
		bsa_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.cell_idx(CNT_W'(g)),
			.tok_i   (chain[g]),
			.tok_o   (chain[g+1])
		);
	end

	assign tail = chain[NUM_WORDS];

	// an allocate that no cell served found every word taken
	always_comb begin
		fin = tail.rsp;
		if (!tail.done) begin
			fin        = '0;
			fin.status = ST_FULL;
		end
	end

	assign out_free = !out_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			wiu_q        <= '0;
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (tail.valid) begin
				busy_q <= 1'b0;
			end
			if (tail.valid) begin
				wiu_q <= tail.wiu;
			end
			if (out_free) begin
				if (hold_valid_q) begin
					out_valid_q  <= 1'b1;
					hold_valid_q <= 1'b0;
				end else begin
					out_valid_q <= tail.valid;
				end
			end else if (tail.valid) begin
				hold_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			if (hold_valid_q) begin
				out_q <= hold_q;
			end else if (tail.valid) begin
				out_q <= fin;
			end
		end else if (tail.valid) begin
			hold_q <= fin;
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.read_bit      = out_q.read_bit;
	assign rsp.granted_index = out_q.granted_index;
	assign rsp.status        = out_q.status;

endmodule

@@ design/bsa_cell.sv @@
// bsa_cell: one word of the bitmap plus one token register; serves get, set and allocate
// for its own word and hands the token on to the next cell every cycle.
// Depends on bsa_pkg.
module bsa_cell
	import bsa_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [CNT_W-1:0] cell_idx,
	input  tok_t             tok_i,
	output tok_t             tok_o
);

	logic [WORD_BITS-1:0] word_q;
	logic [WORD_BITS-1:0] word_d;
	tok_t                 tok_q;
	tok_t                 tok_d;
	logic [WORD_BITS-1:0] free;
	logic [OFF_W-1:0]     pos;
	logic [WSEL_W-1:0]    word_sel;
	logic [OFF_W-1:0]     off;
	logic                 live;
	logic                 hit;
	logic                 can_alloc;
	logic [CNT_W-1:0]     wiu_grow;

	assign word_sel = tok_i.idx[IDX_W-1:OFF_W];
	assign off      = tok_i.idx[OFF_W-1:0];
	assign free     = ~word_q;
	assign live     = tok_i.valid && !tok_i.done;
	assign hit      = live && (CMP_W'(word_sel) == CMP_W'(cell_idx));
	// words past the count are still zero, so the first unused cell grants bit 0
	assign can_alloc = live && (cell_idx <= tok_i.wiu) && (|free);
	assign wiu_grow  = (cell_idx >= tok_i.wiu) ? cell_idx + CNT_W'(1) : tok_i.wiu;

	// lowest clear bit
	always_comb begin
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (free[i]) begin
				pos = OFF_W'(i);
			end
		end
	end

	always_comb begin
		tok_d  = tok_i;
		word_d = word_q;
		case (tok_i.kind)
			KIND_GET: begin
				if (hit) begin
					tok_d.done         = 1'b1;
					tok_d.rsp.read_bit = word_q[off];
					tok_d.rsp.status   = ST_OK;
				end
			end
			KIND_SET: begin
				if (hit) begin
					word_d[off]      = tok_i.val;
					tok_d.done       = 1'b1;
					tok_d.wiu        = wiu_grow;
					tok_d.rsp.status = ST_OK;
				end
			end
			KIND_ALLOC: begin
				if (can_alloc) begin
					word_d[pos]             = 1'b1;
					tok_d.done              = 1'b1;
					tok_d.wiu               = wiu_grow;
					tok_d.rsp.granted_index = IDX_W'({cell_idx, pos});
					tok_d.rsp.status        = ST_OK;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_q <= '0;
			tok_q  <= '0;
		end else begin
			word_q <= word_d;
			tok_q  <= tok_d;
		end
	end

	assign tok_o = tok_q;

endmodule
